>>> src/rcfd_pkg.sv
// shared constants and the channel centering function of the frame decoder
`default_nettype none
package rcfd_pkg;

	// frame layout
	localparam int FRAME_BYTES   = 18;
	localparam int CENTER_OFFSET = 1024;
	localparam int STICK_LIMIT   = 660;
	localparam int COUNT_BITS    = 16;

	// keyboard word
	localparam int NUM_KEYS   = 16;
	localparam int NUM_GROUPS = 3;
	localparam int SHIFT_BIT  = 4;
	localparam int CTRL_BIT   = 5;

	// item function codes (input tuser)
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// result kind codes (output tuser)
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	// counter groups
	localparam logic [1:0] GROUP_PLAIN = 2'd0;
	localparam logic [1:0] GROUP_CTRL  = 2'd1;
	localparam logic [1:0] GROUP_SHIFT = 2'd2;
	localparam logic [1:0] GROUP_NONE  = 2'd3;

	// subtract the center offset, zero when outside the stick limit
	function automatic logic [10:0] centre_channel(input logic [10:0] raw);
		logic signed [12:0] v;
		logic signed [12:0] lim;
		lim = 13'(STICK_LIMIT);
		v   = $signed({2'b00, raw} - 13'(CENTER_OFFSET));
		if (v > lim || v < -lim) begin
			return 11'd0;
		end
		return v[10:0];
	endfunction

endpackage
`default_nettype wire

>>> src/rc_receiver_frame_decoder_unit.sv
// top level of the remote control receiver frame decoder
`default_nettype none
// Collects serial frame bytes into an 18-byte frame (s_axis_tlast closes a burst) and turns
// a burst of exactly 18 bytes into one decoded result; shorter or longer bursts give no result.
// A read item (s_axis_tuser high) answers with one 16-bit key press counter. A counter read
// does the synchronous read of the counter memory first and then registers the answer. A good
// frame gives its result in the next cycle and then starts the press counter update: a
// read-modify-write sweep over the 48 entries of the counter memory, which reads one entry
// while it writes back the previous one; no item is accepted until the sweep is done.
// Counters start at zero through per-entry valid bits, so no clearing pass runs after reset.
// An item is accepted only when the output register is empty or being drained in that cycle.
module rc_receiver_frame_decoder_unit #(
	parameter int COUNT_BITS = rcfd_pkg::COUNT_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// data_byte[7:0], counter_group[9:8], counter_key[13:10], zero [15:14]
	input  wire  [15:0]  s_axis_tdata,
	// func[0]
	input  wire          s_axis_tuser,
	input  wire          s_axis_tlast,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// stick_right_h[10:0], stick_right_v[21:11], stick_left_h[32:22], stick_left_v[43:33],
	// dial_value[54:44], switch_pair[58:55], mouse_dx[74:59], mouse_dy[90:75],
	// mouse_left[98:91], mouse_right[106:99], keys_or_count[122:107], zero [127:123]
	output logic [127:0] m_axis_tdata,
	// kind[0]
	output logic         m_axis_tuser
);
	import rcfd_pkg::*;

	localparam int NUM_CNT  = NUM_GROUPS * NUM_KEYS;
	localparam int IDX_BITS = $clog2(NUM_CNT);
	localparam int BC_BITS  = 5;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]            state_q;
	logic [BC_BITS-1:0]    byte_cnt_q;
	logic [7:0]            frame_q [FRAME_BYTES];
	logic [15:0]           prev_keys_q;
	logic [15:0]           now_keys_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [NUM_CNT-1:0]    vld_q;
	logic [COUNT_BITS-1:0] cnt_mem [NUM_CNT];
	logic                  m_valid_q;

	logic [COUNT_BITS-1:0] rd_s1;
	logic                  rv_s1;
	logic                  g3_s1;
	logic                  inc_s1;
	logic [IDX_BITS-1:0]   wa_s1;

	logic [7:0]            in_byte;
	logic [1:0]            in_grp;
	logic [3:0]            in_key;
	logic                  accept;
	logic                  take_byte;
	logic                  good_frame;
	logic                  out_xfer;
	logic [IDX_BITS-1:0]   rd_addr;
	logic                  inc_now;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [31:0]           cnt_ext;
	logic [15:0]           keys_word;

	// input fields and handshake
	assign in_byte    = s_axis_tdata[7:0];
	assign in_grp     = s_axis_tdata[9:8];
	assign in_key     = s_axis_tdata[13:10];
	assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign take_byte  = accept && (s_axis_tuser == FUNC_BYTE);
	assign good_frame = take_byte && s_axis_tlast && (byte_cnt_q == BC_BITS'(FRAME_BYTES - 1));
	assign out_xfer   = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign keys_word  = {frame_q[15], frame_q[14]};

	// counter memory address: sweep index, or the requested counter
	always_comb begin
		if (state_q == ST_SWEEP) begin
			rd_addr = idx_q;
		end else if (in_grp == GROUP_NONE) begin
			rd_addr = '0;
		end else begin
			rd_addr = IDX_BITS'({in_grp, in_key});
		end
	end

	// increment decision for the entry the sweep reads now
	always_comb begin
		logic [15:0] c_now;
		logic [15:0] s_now;
		logic [15:0] c_last;
		logic [15:0] s_last;
		logic [1:0]  grp;
		logic [3:0]  key;
		c_now  = now_keys_q[CTRL_BIT] ? now_keys_q : 16'd0;
		s_now  = now_keys_q[SHIFT_BIT] ? now_keys_q : 16'd0;
		c_last = prev_keys_q[CTRL_BIT] ? prev_keys_q : 16'd0;
		s_last = prev_keys_q[SHIFT_BIT] ? prev_keys_q : 16'd0;
		grp    = idx_q[IDX_BITS-1:4];
		key    = idx_q[3:0];
		case (grp)
			GROUP_PLAIN: inc_now = now_keys_q[key] && !prev_keys_q[key] && !c_now[key] &&
			                       !s_now[key];
			GROUP_CTRL:  inc_now = c_now[key] && !c_last[key];
			GROUP_SHIFT: inc_now = s_now[key] && !s_last[key];
			default:     inc_now = 1'b0;
		endcase
		if (key == 4'(SHIFT_BIT) || key == 4'(CTRL_BIT)) begin
			inc_now = 1'b0;
		end
	end

	// current value of the entry read last cycle, zero until first written
	assign cur_cnt = rv_s1 ? rd_s1 : '0;
	assign cnt_ext = 32'(cur_cnt);

	// counter memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (inc_s1) begin
			cnt_mem[wa_s1] <= cur_cnt + COUNT_BITS'(1);
		end
		rd_s1 <= cnt_mem[rd_addr];
	end

	// read stage side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1  <= 1'b0;
			g3_s1  <= 1'b0;
			inc_s1 <= 1'b0;
			wa_s1  <= '0;
			vld_q  <= '0;
		end else begin
			rv_s1  <= vld_q[rd_addr];
			g3_s1  <= (in_grp == GROUP_NONE);
			inc_s1 <= (state_q == ST_SWEEP) && inc_now;
			wa_s1  <= idx_q;
			if (inc_s1) begin
				vld_q[wa_s1] <= 1'b1;
			end
		end
	end

	// frame byte store
	always_ff @(posedge clk) begin
		if (take_byte && byte_cnt_q < BC_BITS'(FRAME_BYTES)) begin
			frame_q[byte_cnt_q] <= in_byte;
		end
	end

	// sequencer, byte count and keyboard history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_cnt_q  <= '0;
			prev_keys_q <= '0;
			now_keys_q  <= '0;
			idx_q       <= '0;
		end else begin
			if (take_byte) begin
				if (s_axis_tlast) begin
					byte_cnt_q <= '0;
				end else if (byte_cnt_q != '1) begin
					byte_cnt_q <= byte_cnt_q + BC_BITS'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (good_frame) begin
						now_keys_q <= keys_word;
						idx_q      <= '0;
						state_q    <= ST_SWEEP;
					end else if (accept && s_axis_tuser == FUNC_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (idx_q == IDX_BITS'(NUM_CNT - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_BITS'(1);
					end
				end
				ST_DRAIN: begin
					prev_keys_q <= now_keys_q;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (good_frame || state_q == ST_READ) begin
			m_valid_q <= 1'b1;
		end else if (out_xfer) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload: decoded frame or counter answer
	always_ff @(posedge clk) begin
		if (good_frame) begin
			m_axis_tuser         <= KIND_FRAME;
			m_axis_tdata[10:0]   <= centre_channel({frame_q[1][2:0], frame_q[0]});
			m_axis_tdata[21:11]  <= centre_channel({frame_q[2][5:0], frame_q[1][7:3]});
			m_axis_tdata[32:22]  <= centre_channel({frame_q[4][0], frame_q[3], frame_q[2][7:6]});
			m_axis_tdata[43:33]  <= centre_channel({frame_q[5][3:0], frame_q[4][7:1]});
			m_axis_tdata[54:44]  <= centre_channel({in_byte[2:0], frame_q[16]});
			m_axis_tdata[58:55]  <= frame_q[5][7:4];
			m_axis_tdata[74:59]  <= {frame_q[7], frame_q[6]};
			m_axis_tdata[90:75]  <= {frame_q[9], frame_q[8]};
			m_axis_tdata[98:91]  <= frame_q[12];
			m_axis_tdata[106:99] <= frame_q[13];
			m_axis_tdata[122:107] <= keys_word;
			m_axis_tdata[127:123] <= '0;
		end else if (state_q == ST_READ) begin
			m_axis_tuser          <= KIND_COUNT;
			m_axis_tdata[106:0]   <= '0;
			m_axis_tdata[122:107] <= g3_s1 ? 16'd0 : cnt_ext[15:0];
			m_axis_tdata[127:123] <= '0;
		end
	end

	// checks on the sequencer and the output register
	a_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		inc_s1 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("counter write outside the update sweep");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!m_valid_q || m_axis_tready))
		else $error("item accepted while a result is stuck");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (m_axis_tvalid && m_axis_tuser == KIND_COUNT))
		else $error("counter read gave no answer");

	a_frame_result: assert property (@(posedge clk) disable iff (!arst_n)
		good_frame |=> (state_q == ST_SWEEP && m_axis_tvalid && m_axis_tuser == KIND_FRAME))
		else $error("good frame did not give a result and start the sweep");

endmodule
`default_nettype wire

>>> bench/tb_rc_receiver_frame_decoder_unit.sv
// self-checking stream testbench for the remote control receiver frame decoder
module tb_rc_receiver_frame_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rcfd_pkg::*;

	localparam int ITEM_TARGET      = 1700;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 100;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int MAX_PRINTED      = 100;
	localparam int BURST_SATURATE   = 31;

	// one input transfer; hold means wait for every answer before offering it
	typedef struct packed {
		logic       hold;
		logic       func;
		logic [7:0] data_byte;
		logic       frame_end;
		logic [1:0] counter_group;
		logic [3:0] counter_key;
	} rc_item_t;

	// one output transfer, laid out as {tuser, tdata}
	typedef struct packed {
		logic        kind;
		logic [4:0]  pad;
		logic [15:0] keys_or_count;
		logic [7:0]  mouse_right;
		logic [7:0]  mouse_left;
		logic [15:0] mouse_dy;
		logic [15:0] mouse_dx;
		logic [3:0]  switch_pair;
		logic [10:0] dial_value;
		logic [10:0] stick_left_v;
		logic [10:0] stick_left_h;
		logic [10:0] stick_right_v;
		logic [10:0] stick_right_h;
	} rc_answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;

	rc_item_t   rx_items[$];
	rc_answer_t awaited_answers[$];
	int         items_made = 0;
	int         error_count = 0;
	int         answer_index = 0;
	int         idle_cycles = 0;

	// decoder state mirrored by the testbench
	logic [7:0]            frame_bytes [FRAME_BYTES];
	int                    burst_len = 0;
	logic [15:0]           last_keys = '0;
	logic [COUNT_BITS-1:0] press_count [NUM_GROUPS*NUM_KEYS];

	// sender burst control
	int burst_left = 0;
	int gap_left = 0;

	// receiver stall control
	int   answers_taken = 0;
	int   sink_hold_left = 0;
	int   sink_hold_at = -1;
	int   sink_mode = 0;
	int   sink_mode_left = 0;
	logic [1:0] sink_phase = '0;

	rc_receiver_frame_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	initial begin
		foreach (press_count[k]) press_count[k] = '0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		// keep the log short when something is badly broken
		if (error_count <= MAX_PRINTED) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// raw 11-bit channel minus the center, zero outside the stick travel
	function automatic logic [10:0] centered(input logic [10:0] raw);
		int v;
		v = int'(raw) - CENTER_OFFSET;
		if (v > STICK_LIMIT || v < -STICK_LIMIT) begin
			v = 0;
		end
		return v[10:0];
	endfunction

	// per-key rising edge counting for plain, ctrl and shift presses
	task automatic count_key_presses(input logic [15:0] now);
		logic [15:0] ctrl_now, shift_now, ctrl_last, shift_last;
		int i;
		ctrl_now   = now[CTRL_BIT] ? now : '0;
		shift_now  = now[SHIFT_BIT] ? now : '0;
		ctrl_last  = last_keys[CTRL_BIT] ? last_keys : '0;
		shift_last = last_keys[SHIFT_BIT] ? last_keys : '0;
		for (i = 0; i < NUM_KEYS; i++) begin
			if (i == SHIFT_BIT || i == CTRL_BIT) begin
				continue;
			end
			if (now[i] && !last_keys[i] && !ctrl_now[i] && !shift_now[i]) begin
				press_count[i]++;
			end
			if (ctrl_now[i] && !ctrl_last[i]) begin
				press_count[NUM_KEYS + i]++;
			end
			if (shift_now[i] && !shift_last[i]) begin
				press_count[2*NUM_KEYS + i]++;
			end
		end
		last_keys = now;
	endtask

	// advance the mirrored decoder by one accepted item, queue any answer
	task automatic decode_rc_item(input rc_item_t it);
		rc_answer_t a;
		logic [8*FRAME_BYTES-1:0] f;
		int i;
		a = '0;
		if (it.func == FUNC_READ) begin
			a.kind = KIND_COUNT;
			if (it.counter_group != GROUP_NONE) begin
				a.keys_or_count =
					16'(press_count[int'(it.counter_group)*NUM_KEYS + int'(it.counter_key)]);
			end
			awaited_answers.push_back(a);
			return;
		end
		if (burst_len < FRAME_BYTES) begin
			frame_bytes[burst_len] = it.data_byte;
		end
		if (burst_len < BURST_SATURATE) begin
			burst_len++;
		end
		if (!it.frame_end) begin
			return;
		end
		if (burst_len != FRAME_BYTES) begin
			burst_len = 0;
			return;
		end
		burst_len = 0;
		for (i = 0; i < FRAME_BYTES; i++) begin
			f[8*i +: 8] = frame_bytes[i];
		end
		a.kind          = KIND_FRAME;
		a.stick_right_h = centered(f[10:0]);
		a.stick_right_v = centered(f[21:11]);
		a.stick_left_h  = centered(f[32:22]);
		a.stick_left_v  = centered(f[43:33]);
		a.dial_value    = centered(f[138:128]);
		a.switch_pair   = f[47:44];
		a.mouse_dx      = f[63:48];
		a.mouse_dy      = f[79:64];
		a.mouse_left    = f[103:96];
		a.mouse_right   = f[111:104];
		a.keys_or_count = f[127:112];
		awaited_answers.push_back(a);
		count_key_presses(f[127:112]);
	endtask

	task automatic check_field(input string name, input logic [15:0] got_v,
			input logic [15:0] want_v);
		if (got_v !== want_v) begin
			report_mismatch($sformatf("answer %0d %s: got %h expected %h",
				answer_index, name, got_v, want_v));
		end
	endtask

	task automatic compare_answer(input rc_answer_t got, input rc_answer_t want);
		check_field("kind", 16'(got.kind), 16'(want.kind));
		check_field("pad", 16'(got.pad), 16'(want.pad));
		check_field("stick_right_h", 16'(got.stick_right_h), 16'(want.stick_right_h));
		check_field("stick_right_v", 16'(got.stick_right_v), 16'(want.stick_right_v));
		check_field("stick_left_h", 16'(got.stick_left_h), 16'(want.stick_left_h));
		check_field("stick_left_v", 16'(got.stick_left_v), 16'(want.stick_left_v));
		check_field("dial_value", 16'(got.dial_value), 16'(want.dial_value));
		check_field("switch_pair", 16'(got.switch_pair), 16'(want.switch_pair));
		check_field("mouse_dx", got.mouse_dx, want.mouse_dx);
		check_field("mouse_dy", got.mouse_dy, want.mouse_dy);
		check_field("mouse_left", 16'(got.mouse_left), 16'(want.mouse_left));
		check_field("mouse_right", 16'(got.mouse_right), 16'(want.mouse_right));
		check_field("keys_or_count", got.keys_or_count, want.keys_or_count);
	endtask

	// stimulus builders
	task automatic push_byte(input logic [7:0] data, input logic fend, input logic hold);
		rc_item_t it;
		it.hold          = hold;
		it.func          = FUNC_BYTE;
		it.data_byte     = data;
		it.frame_end     = fend;
		it.counter_group = 2'($urandom_range(0, 3));
		it.counter_key   = 4'($urandom_range(0, 15));
		rx_items.push_back(it);
		items_made++;
	endtask

	task automatic push_read(input logic [1:0] grp, input logic [3:0] key);
		rc_item_t it;
		it.hold          = 1'b0;
		it.func          = FUNC_READ;
		it.data_byte     = 8'($urandom_range(0, 255));
		it.frame_end     = 1'($urandom_range(0, 1));
		it.counter_group = grp;
		it.counter_key   = key;
		rx_items.push_back(it);
		items_made++;
	endtask

	// one 18-byte burst, optionally with a counter read slipped in between bytes
	task automatic push_frame(input logic [8*FRAME_BYTES-1:0] f, input logic hold,
			input logic mixed);
		int read_at;
		int i;
		read_at = mixed ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
		for (i = 0; i < FRAME_BYTES; i++) begin
			if (i == read_at) begin
				push_read(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
			end
			push_byte(f[8*i +: 8], i == FRAME_BYTES - 1, hold && i == 0);
		end
	endtask

	task automatic push_broken_burst();
		int len;
		int i;
		case ($urandom_range(0, 5))
			0: len = FRAME_BYTES - 1;
			1: len = FRAME_BYTES + 1;
			2: len = $urandom_range(BURST_SATURATE + 1, 40);
			default: begin
				len = $urandom_range(1, 40);
				if (len == FRAME_BYTES) begin
					len = FRAME_BYTES - 1;
				end
			end
		endcase
		for (i = 0; i < len; i++) begin
			push_byte(8'($urandom_range(0, 255)), i == len - 1, 1'b0);
		end
	endtask

	// mostly inside the stick travel, sometimes at or past its edges
	function automatic logic [10:0] rand_channel();
		logic [10:0] edges [7];
		edges = '{11'd0, 11'd363, 11'd364, 11'd1024, 11'd1684, 11'd1685, 11'd2047};
		case ($urandom_range(0, 9))
			0: return edges[$urandom_range(0, 6)];
			1: return 11'($urandom_range(0, 2047));
			default: return 11'(CENTER_OFFSET - STICK_LIMIT + $urandom_range(0, 2*STICK_LIMIT));
		endcase
	endfunction

	function automatic logic [15:0] rand_keys();
		logic [15:0] k;
		case ($urandom_range(0, 9))
			0: k = '0;
			1: k = '1;
			default: begin
				k = 16'($urandom & $urandom);
				k[SHIFT_BIT] = ($urandom_range(0, 2) == 0);
				k[CTRL_BIT]  = ($urandom_range(0, 2) == 0);
			end
		endcase
		return k;
	endfunction

	function automatic logic [8*FRAME_BYTES-1:0] rand_frame();
		logic [8*FRAME_BYTES-1:0] f;
		f = (8*FRAME_BYTES)'({$urandom, $urandom, $urandom, $urandom, $urandom});
		f[10:0]    = rand_channel();
		f[21:11]   = rand_channel();
		f[32:22]   = rand_channel();
		f[43:33]   = rand_channel();
		f[138:128] = rand_channel();
		f[127:112] = rand_keys();
		return f;
	endfunction

	// driver: offers queued items in random bursts, predicts on each transfer
	always @(posedge clk) begin
		logic offer;
		offer = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_rc_item(rx_items[0]);
				rx_items.pop_front();
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				offer = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (rx_items.size() != 0 &&
					!(rx_items[0].hold && awaited_answers.size() != 0)) begin
				offer = 1'b1;
				s_axis_tdata <= {2'b00, rx_items[0].counter_key, rx_items[0].counter_group,
					rx_items[0].data_byte};
				s_axis_tuser <= rx_items[0].func;
				s_axis_tlast <= rx_items[0].frame_end;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
		end
		s_axis_tvalid <= offer;
	end

	// receiver: changing stall pattern plus two long hold-offs
	always @(posedge clk) begin
		logic ready_next;
		ready_next = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				answers_taken++;
			end
			if (sink_hold_left == 0 && answers_taken != sink_hold_at &&
					(answers_taken == 12 || answers_taken == 70)) begin
				sink_hold_left = SINK_HOLD_CYCLES;
				sink_hold_at   = answers_taken;
			end
			if (sink_mode_left == 0) begin
				sink_mode      = $urandom_range(0, 3);
				sink_mode_left = $urandom_range(20, 200);
			end else begin
				sink_mode_left--;
			end
			sink_phase++;
			if (sink_hold_left != 0) begin
				sink_hold_left--;
			end else begin
				case (sink_mode)
					0: ready_next = 1'b1;
					1: ready_next = 1'($urandom_range(0, 1));
					2: ready_next = (sink_phase == 2'd0);
					default: ready_next = ($urandom_range(0, 4) != 0);
				endcase
			end
		end
		m_axis_tready <= ready_next;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited_answers.size() == 0) begin
				report_mismatch($sformatf("answer %0d arrived with none expected",
					answer_index));
			end else begin
				compare_answer({m_axis_tuser, m_axis_tdata}, awaited_answers[0]);
				awaited_answers.pop_front();
			end
			answer_index++;
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
				!arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [8*FRAME_BYTES-1:0] f;
		int frames_made;
		int n;
		int i;
		frames_made = 0;

		// reads straight after reset, the unused group, a one-byte burst
		push_read(GROUP_PLAIN, 4'd0);
		push_read(GROUP_NONE, 4'd15);
		push_byte(8'hFF, 1'b1, 1'b0);

		// channels at and past both edges, extreme mouse values, every key with ctrl and shift
		f = '0;
		f[10:0]     = 11'd0;
		f[21:11]    = 11'd2047;
		f[32:22]    = 11'd364;
		f[43:33]    = 11'd1684;
		f[47:44]    = 4'b1001;
		f[63:48]    = 16'h8000;
		f[79:64]    = 16'h7FFF;
		f[95:80]    = 16'h5AA5;
		f[103:96]   = 8'hFF;
		f[111:104]  = 8'h00;
		f[127:112]  = 16'hFFFF;
		f[138:128]  = 11'd1685;
		f[143:139]  = 5'h1F;
		push_frame(f, 1'b0, 1'b0);

		// ctrl counters moved; ctrl and shift keys themselves never count
		push_read(GROUP_CTRL, 4'd0);
		push_read(GROUP_CTRL, 4'(CTRL_BIT));
		push_read(GROUP_SHIFT, 4'(SHIFT_BIT));
		push_read(GROUP_PLAIN, 4'd15);

		// random part: mostly good frames, some reads and broken bursts
		while (items_made < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++) begin
						push_read(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
					end
				end
				3, 4, 5: push_broken_burst();
				default: begin
					push_frame(rand_frame(), frames_made % 25 == 0, $urandom_range(0, 6) == 0);
					frames_made++;
				end
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_items.size() != 0 || awaited_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_answers.size() != 0) begin
			report_mismatch($sformatf("%0d answers never arrived", awaited_answers.size()));
		end
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
